// File: hw/rtl/aesf_pkg.sv
// Shared types and constants for the attitude error state feedback unit.
package aesf_pkg;

  localparam int unsigned DEF_SAMPLE_WIDTH = 16;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ERR_W      = 34;
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned PROD_W     = MUL_A_W + GAIN_W;
  localparam int unsigned ACC_W      = 56;
  localparam int unsigned RATE_SHIFT = 19;
  localparam int unsigned OUT_SHIFT  = 21;
  localparam int unsigned TORQUE_W   = 32;
  localparam int unsigned NUM_CFG    = 6;
  localparam int unsigned CFG_W      = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MAT_DEPTH  = 9;
  localparam int unsigned VEC_DEPTH  = 3;

  typedef enum logic [1:0] {
    FUNC_LOAD_CUR  = 2'd0,
    FUNC_LOAD_DES  = 2'd1,
    FUNC_LOAD_RATE = 2'd2,
    FUNC_COMPUTE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  // One multiply-accumulate step plus the load strobe.
  typedef struct packed {
    logic       load;
    logic       valid;
    logic       tau;
    logic [3:0] idx_d;
    logic [3:0] idx_c;
    logic [1:0] sel;
    logic       rate_src;
    logic       sub;
    logic       first;
    logic       done;
    logic [1:0] grp;
  } cmd_t;

endpackage

// File: hw/rtl/attitude_error_state_feedback_unit.sv
// Top level of the attitude error state feedback unit.
// Usage:
//   Input beats are taken when start is high and busy is low. func_i selects
//   a load of the current attitude, the desired attitude or the body rate
//   (element index_i, value value_i), or a compute.
//   A load beat leaves busy low.
//   A compute runs 36 multiply-accumulate steps on one shared 34x16
//   multiplier (18 for the attitude error, 18 for the torques) and then
//   drains the pipeline; busy stays high through the run and the drain.
//   Results appear with strobe_o high for one cycle each, for axis x, y
//   and z in that order; last_o marks z.
//   A new beat may be taken in the cycle the z result is shown.
//   The receiver cannot stall: each result is accepted in its strobe cycle.
//   The user must write the gain registers on the cfg channel (always ready) only while idle;
//   the block does not enforce it. Reset clears the stores, the gains and the sequencer.
module attitude_error_state_feedback_unit #(
  parameter int unsigned SAMPLE_WIDTH = aesf_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           func_i,
  input  logic [3:0]                           index_i,
  input  logic signed [aesf_pkg::VALUE_W-1:0]  value_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [aesf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [aesf_pkg::CFG_W-1:0]           cfg_data_i,
  output logic                                 strobe_o,
  output logic [1:0]                           axis_o,
  output logic signed [aesf_pkg::TORQUE_W-1:0] torque_o,
  output logic                                 last_o
);

  aesf_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  aesf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  aesf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .strobe_o    (strobe_o),
    .axis_o      (axis_o),
    .torque_o    (torque_o),
    .last_o      (last_o)
  );

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == aesf_pkg::FUNC_COMPUTE) |=> busy)
    else $error("compute beat did not raise busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i != aesf_pkg::FUNC_COMPUTE) |=> !busy)
    else $error("load beat raised busy");

  a_last_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (last_o == (axis_o == aesf_pkg::AXIS_Z)))
    else $error("last does not match z axis");

  a_y_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (axis_o == aesf_pkg::AXIS_Y) |->
      $past(strobe_o, 6) && ($past(axis_o, 6) == aesf_pkg::AXIS_X))
    else $error("y result not six cycles after x");

  a_z_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (axis_o == aesf_pkg::AXIS_Z) |->
      $past(strobe_o, 6) && ($past(axis_o, 6) == aesf_pkg::AXIS_Y))
    else $error("z result not six cycles after y");

endmodule

// File: hw/rtl/aesf_ctrl.sv
// Sequencer that walks the attitude error and torque multiply-accumulate steps.
module aesf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         func_i,
  output logic               busy,
  output aesf_pkg::cmd_t     cmd_o
);

  aesf_pkg::state_e state_q, state_d;
  logic       phase_q, phase_d;
  logic [1:0] grp_q, grp_d;
  logic [2:0] term_q, term_d;
  logic       flush_q, flush_d;

  logic       accept;
  logic [1:0] k;
  logic [1:0] col_a;
  logic [1:0] col_b;

  assign busy   = (state_q != aesf_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesf_pkg::ST_IDLE;
      phase_q <= 1'b0;
      grp_q   <= 2'd0;
      term_q  <= 3'd0;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      grp_q   <= grp_d;
      term_q  <= term_d;
      flush_q <= flush_d;
    end
  end

  always_comb begin
    unique case (grp_q)
      2'd0:    begin col_a = 2'd2; col_b = 2'd1; end
      2'd1:    begin col_a = 2'd0; col_b = 2'd2; end
      2'd2:    begin col_a = 2'd1; col_b = 2'd0; end
      default: begin col_a = 2'd0; col_b = 2'd0; end
    endcase
  end

  assign k = term_q[2:1];

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    grp_d   = grp_q;
    term_d  = term_q;
    flush_d = flush_q;

    cmd_o          = '0;
    cmd_o.load     = accept && (func_i != aesf_pkg::FUNC_COMPUTE);
    cmd_o.tau      = phase_q;
    cmd_o.grp      = grp_q;
    cmd_o.idx_d    = 4'(k) * 4'd3 + 4'(term_q[0] ? col_b : col_a);
    cmd_o.idx_c    = 4'(k) * 4'd3 + 4'(term_q[0] ? col_a : col_b);
    cmd_o.rate_src = phase_q && (term_q >= 3'd3);
    cmd_o.sel      = phase_q ? ((term_q >= 3'd3) ? 2'(term_q - 3'd3) : term_q[1:0]) : grp_q;
    cmd_o.sub      = phase_q ? 1'b1 : term_q[0];
    cmd_o.first    = (term_q == 3'd0);
    cmd_o.done     = (term_q == 3'd5);

    unique case (state_q)
      aesf_pkg::ST_IDLE: begin
        if (accept && (func_i == aesf_pkg::FUNC_COMPUTE)) begin
          state_d = aesf_pkg::ST_RUN;
          phase_d = 1'b0;
          grp_d   = 2'd0;
          term_d  = 3'd0;
        end
      end
      aesf_pkg::ST_RUN: begin
        cmd_o.valid = 1'b1;
        if (term_q == 3'd5) begin
          term_d = 3'd0;
          if (grp_q == 2'd2) begin
            grp_d = 2'd0;
            if (phase_q) begin
              state_d = aesf_pkg::ST_FLUSH;
              flush_d = 1'b0;
            end else begin
              phase_d = 1'b1;
            end
          end else begin
            grp_d = grp_q + 2'd1;
          end
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      aesf_pkg::ST_FLUSH: begin
        flush_d = 1'b1;
        if (flush_q) begin
          state_d = aesf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aesf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/aesf_datapath.sv
// Stores, gain registers, shared multiplier, accumulator and torque output stage.
module aesf_datapath #(
  parameter int unsigned SAMPLE_WIDTH = aesf_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  aesf_pkg::cmd_t                      cmd_i,
  input  logic [1:0]                          func_i,
  input  logic [3:0]                          index_i,
  input  logic signed [aesf_pkg::VALUE_W-1:0] value_i,
  input  logic                                cfg_we_i,
  input  logic [aesf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [aesf_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                                strobe_o,
  output logic [1:0]                          axis_o,
  output logic signed [aesf_pkg::TORQUE_W-1:0] torque_o,
  output logic                                last_o
);

  localparam int unsigned VALUE_BITS =
      (SAMPLE_WIDTH < aesf_pkg::VALUE_W) ? SAMPLE_WIDTH : aesf_pkg::VALUE_W;
  localparam int unsigned SHIFTED_W = aesf_pkg::ACC_W - aesf_pkg::OUT_SHIFT;

  typedef struct packed {
    logic       valid;
    logic       tau;
    logic       shift;
    logic       sub;
    logic       first;
    logic       done;
    logic [1:0] grp;
  } stage_t;

  logic [VALUE_BITS-1:0] cur_q  [aesf_pkg::MAT_DEPTH];
  logic [VALUE_BITS-1:0] des_q  [aesf_pkg::MAT_DEPTH];
  logic [VALUE_BITS-1:0] rate_q [aesf_pkg::VEC_DEPTH];
  logic [aesf_pkg::CFG_W-1:0] gain_q [aesf_pkg::NUM_CFG];
  logic signed [aesf_pkg::ERR_W-1:0] err_q [aesf_pkg::VEC_DEPTH];

  logic signed [aesf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [aesf_pkg::GAIN_W-1:0]  mul_b;
  logic [aesf_pkg::CFG_W-1:0]          gain_word;
  logic signed [aesf_pkg::PROD_W-1:0]  prod_d, prod_q;
  stage_t                              st1_q;

  logic signed [aesf_pkg::ACC_W-1:0] acc_q, acc_d, acc_base, prod_ext, aligned;
  logic                              tau_done_q;
  logic [1:0]                        axis2_q;

  logic signed [aesf_pkg::ACC_W-1:0] rnd;
  logic signed [SHIFTED_W-1:0]       shifted;
  logic signed [aesf_pkg::TORQUE_W-1:0] sat;

  logic strobe_q, last_q;
  logic [1:0] axis_q;
  logic signed [aesf_pkg::TORQUE_W-1:0] torque_q;

  // Load beats and configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(aesf_pkg::MAT_DEPTH); i++) begin
        cur_q[i] <= '0;
        des_q[i] <= '0;
      end
      for (int i = 0; i < int'(aesf_pkg::VEC_DEPTH); i++) begin
        rate_q[i] <= '0;
      end
      for (int i = 0; i < int'(aesf_pkg::NUM_CFG); i++) begin
        gain_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        unique case (func_i)
          aesf_pkg::FUNC_LOAD_CUR: begin
            if (index_i < 4'(aesf_pkg::MAT_DEPTH)) begin
              cur_q[index_i] <= value_i[VALUE_BITS-1:0];
            end
          end
          aesf_pkg::FUNC_LOAD_DES: begin
            if (index_i < 4'(aesf_pkg::MAT_DEPTH)) begin
              des_q[index_i] <= value_i[VALUE_BITS-1:0];
            end
          end
          aesf_pkg::FUNC_LOAD_RATE: begin
            if (index_i < 4'(aesf_pkg::VEC_DEPTH)) begin
              rate_q[index_i[1:0]] <= value_i[VALUE_BITS-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      if (cfg_we_i && (cfg_index_i < aesf_pkg::CFG_IDX_W'(aesf_pkg::NUM_CFG))) begin
        gain_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // Operand selection
  assign gain_word = gain_q[{cmd_i.grp, cmd_i.rate_src}];

  always_comb begin
    if (cmd_i.tau) begin
      mul_a = cmd_i.rate_src ? aesf_pkg::MUL_A_W'($signed(rate_q[cmd_i.sel]))
                             : err_q[cmd_i.sel];
      unique case (cmd_i.sel)
        2'd0:    mul_b = $signed(gain_word[15:0]);
        2'd1:    mul_b = $signed(gain_word[31:16]);
        2'd2:    mul_b = $signed(gain_word[47:32]);
        default: mul_b = '0;
      endcase
    end else begin
      mul_a = aesf_pkg::MUL_A_W'($signed(des_q[cmd_i.idx_d]));
      mul_b = aesf_pkg::GAIN_W'($signed(cur_q[cmd_i.idx_c]));
    end
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q <= '0;
    end else begin
      st1_q.valid <= cmd_i.valid;
      st1_q.tau   <= cmd_i.tau;
      st1_q.shift <= cmd_i.tau && cmd_i.rate_src;
      st1_q.sub   <= cmd_i.sub;
      st1_q.first <= cmd_i.first;
      st1_q.done  <= cmd_i.done;
      st1_q.grp   <= cmd_i.grp;
    end
  end

  // Accumulate
  assign prod_ext = aesf_pkg::ACC_W'(prod_q);
  assign aligned  = st1_q.shift ? (prod_ext <<< aesf_pkg::RATE_SHIFT) : prod_ext;
  assign acc_base = st1_q.first ? '0 : acc_q;
  assign acc_d    = st1_q.sub ? (acc_base - aligned) : (acc_base + aligned);

  always_ff @(posedge clk_i) begin
    if (st1_q.valid) begin
      acc_q <= acc_d;
      if (st1_q.done && !st1_q.tau) begin
        err_q[st1_q.grp] <= acc_d[aesf_pkg::ERR_W-1:0];
      end
    end
    axis2_q <= st1_q.grp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_done_q <= 1'b0;
    end else begin
      tau_done_q <= st1_q.valid && st1_q.tau && st1_q.done;
    end
  end

  // Round to nearest and saturate
  assign rnd     = acc_q + (aesf_pkg::ACC_W'(1) <<< (aesf_pkg::OUT_SHIFT - 1));
  assign shifted = rnd[aesf_pkg::ACC_W-1:aesf_pkg::OUT_SHIFT];

  always_comb begin
    if (shifted[SHIFTED_W-1:aesf_pkg::TORQUE_W-1] == '0 ||
        shifted[SHIFTED_W-1:aesf_pkg::TORQUE_W-1] == '1) begin
      sat = shifted[aesf_pkg::TORQUE_W-1:0];
    end else if (shifted[SHIFTED_W-1]) begin
      sat = {1'b1, {(aesf_pkg::TORQUE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(aesf_pkg::TORQUE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= tau_done_q;
      last_q   <= tau_done_q && (axis2_q == aesf_pkg::AXIS_Z);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tau_done_q) begin
      torque_q <= sat;
      axis_q   <= axis2_q;
    end
  end

  assign strobe_o = strobe_q;
  assign axis_o   = axis_q;
  assign torque_o = torque_q;
  assign last_o   = last_q;

endmodule

// File: tb/sv/attitude_error_state_feedback_unit_tb.sv
// Self-checking testbench for the attitude error state feedback unit.
`timescale 1ns / 1ps

module attitude_error_state_feedback_unit_tb;
  import aesf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 45;
  localparam int PHASE_BEATS  = 68;
  localparam int NUM_PHASES   = 6;
  localparam int PRINT_CAP    = 100;

  localparam longint TORQUE_MAX = 64'sd2147483647;
  localparam longint TORQUE_MIN = -64'sd2147483648;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X_ATT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y_ATT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z_ATT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z_RATE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI    = 3'd7;

  localparam int GAINS_LANES   = 0;
  localparam int GAINS_ALL_MAX = 1;
  localparam int GAINS_ALL_MIN = 2;
  localparam int GAINS_RANDOM  = 3;

  typedef struct {
    axis_e              axis;
    logic signed [31:0] torque;
    logic               last;
  } torque_beat_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start       = 1'b0;
  logic                       busy;
  logic [1:0]                 func_i      = '0;
  logic [3:0]                 index_i     = '0;
  logic signed [VALUE_W-1:0]  value_i     = '0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_W-1:0]           cfg_data_i  = '0;
  logic                       strobe_o;
  logic [1:0]                 axis_o;
  logic signed [TORQUE_W-1:0] torque_o;
  logic                       last_o;

  logic signed [15:0] cur_m [MAT_DEPTH];
  logic signed [15:0] des_m [MAT_DEPTH];
  logic signed [15:0] rate_v [VEC_DEPTH];
  logic [CFG_W-1:0]   gain_reg [NUM_CFG];

  torque_beat_t pending_torques [$];
  torque_beat_t expected_beat;

  int  mismatch_count = 0;
  int  beats_checked  = 0;
  int  item_count     = 0;
  int  compute_count  = 0;
  int  gain_settings  = 0;
  int  cycle_count    = 0;
  bit  gaps_on        = 1'b1;
  bit  start_held     = 1'b0;
  bit  cfg_held       = 1'b0;

  attitude_error_state_feedback_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .strobe_o    (strobe_o),
    .axis_o      (axis_o),
    .torque_o    (torque_o),
    .last_o      (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("attitude_error_state_feedback_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (pending_torques.size() == 0) begin
        report_mismatch("torque beat with none pending, axis", axis_o, -1);
      end else begin
        expected_beat = pending_torques.pop_front();
        beats_checked++;
        if (axis_o !== expected_beat.axis) begin
          report_mismatch("axis", axis_o, expected_beat.axis);
        end
        if (torque_o !== expected_beat.torque) begin
          report_mismatch("torque", longint'(torque_o), longint'(expected_beat.torque));
        end
        if (last_o !== expected_beat.last) begin
          report_mismatch("last", last_o, expected_beat.last);
        end
      end
    end
  end

  function automatic longint attitude_dot(int a, int b);
    longint sum;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      sum += longint'(des_m[k*3+a]) * longint'(cur_m[k*3+b]);
    end
    return sum;
  endfunction

  task automatic predict_torques();
    longint       att_err [3];
    longint       acc;
    longint       ka;
    longint       kr;
    torque_beat_t beat;
    att_err[0] = attitude_dot(2, 1) - attitude_dot(1, 2);
    att_err[1] = attitude_dot(0, 2) - attitude_dot(2, 0);
    att_err[2] = attitude_dot(1, 0) - attitude_dot(0, 1);
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        ka = longint'($signed(gain_reg[2*r][16*j +: 16]));
        kr = longint'($signed(gain_reg[2*r+1][16*j +: 16]));
        acc += ka * att_err[j] + ((kr * longint'(rate_v[j])) <<< RATE_SHIFT);
      end
      acc = (-acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (acc > TORQUE_MAX) acc = TORQUE_MAX;
      if (acc < TORQUE_MIN) acc = TORQUE_MIN;
      beat.axis   = axis_e'(r);
      beat.torque = acc[31:0];
      beat.last   = (beat.axis == AXIS_Z);
      pending_torques.push_back(beat);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic drop_start();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  task automatic drop_cfg();
    if (cfg_held) begin
      cfg_valid_i <= 1'b0;
      cfg_held = 1'b0;
    end
  endtask

  task automatic send_item(func_e f, logic [3:0] idx, logic signed [15:0] v);
    int gap;
    start   <= 1'b1;
    func_i  <= f;
    index_i <= idx;
    value_i <= v;
    start_held = 1'b1;
    do @(posedge clk_i); while (busy);
    item_count++;
    case (f)
      FUNC_LOAD_CUR:  if (idx < MAT_DEPTH) cur_m[idx] = v;
      FUNC_LOAD_DES:  if (idx < MAT_DEPTH) des_m[idx] = v;
      FUNC_LOAD_RATE: if (idx < VEC_DEPTH) rate_v[idx] = v;
      default: begin
        compute_count++;
        predict_torques();
      end
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      drop_start();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    int gap;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_held = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_CFG) gain_reg[idx] = data;
    gap = pick_gap();
    if (gap > 0) begin
      drop_cfg();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold until every torque beat is in and the sequencer has gone quiet
  task automatic settle();
    drop_start();
    while (pending_torques.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh4000;
      3:       return 16'shC000;
      4:       return 16'sh0000;
      5:       return 16'shFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_gain_lane();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0100;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic program_gains(int mode);
    logic [CFG_W-1:0] word;
    for (int r = 0; r < NUM_CFG; r++) begin
      case (mode)
        GAINS_LANES:   word = {rand_gain_lane(), rand_gain_lane(), rand_gain_lane()};
        GAINS_ALL_MAX: word = {3{16'h7FFF}};
        GAINS_ALL_MIN: word = {3{16'h8000}};
        default:       word = {16'($urandom()), 32'($urandom())};
      endcase
      write_gain(CFG_IDX_W'(r), word);
    end
    if ($urandom_range(0, 1) == 1) begin
      write_gain($urandom_range(0, 1) == 1 ? REG_SPARE_HI : REG_SPARE_LO,
                 {16'($urandom()), 32'($urandom())});
    end
    drop_cfg();
    gain_settings++;
  endtask

  task automatic run_frame();
    int          n;
    func_e       f;
    logic [3:0]  idx;
    if ($urandom_range(0, 99) < 15) begin
      for (int k = 0; k < MAT_DEPTH; k++) send_item(FUNC_LOAD_CUR, 4'(k), rand_value());
      for (int k = 0; k < MAT_DEPTH; k++) send_item(FUNC_LOAD_DES, 4'(k), rand_value());
      for (int k = 0; k < VEC_DEPTH; k++) send_item(FUNC_LOAD_RATE, 4'(k), rand_value());
    end else begin
      n = $urandom_range(0, 6);
      for (int k = 0; k < n; k++) begin
        f = func_e'($urandom_range(0, 2));
        if (f == FUNC_LOAD_RATE) begin
          idx = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(3, 15))
                                              : 4'($urandom_range(0, 2));
        end else begin
          idx = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
        end
        send_item(f, idx, rand_value());
      end
    end
    send_item(FUNC_COMPUTE, 4'($urandom()), 16'($urandom()));
  endtask

  task automatic test_power_up();
    send_item(FUNC_COMPUTE, 4'd0, 16'sh0000);
    settle();
  endtask

  task automatic test_directed_cases();
    write_gain(REG_GAIN_X_ATT,  48'h7FFF_8000_0100);
    write_gain(REG_GAIN_X_RATE, 48'h0001_FFFF_7FFF);
    write_gain(REG_GAIN_Y_ATT,  48'h8000_0100_FFFF);
    write_gain(REG_GAIN_Y_RATE, 48'h7FFF_0000_8000);
    write_gain(REG_GAIN_Z_ATT,  48'h0100_7FFF_0001);
    write_gain(REG_GAIN_Z_RATE, 48'hFFFF_8000_0100);
    write_gain(REG_SPARE_LO,    48'hFFFF_FFFF_FFFF);
    write_gain(REG_SPARE_HI,    48'h0000_0000_0000);
    drop_cfg();
    gain_settings++;
    send_item(FUNC_LOAD_CUR,  4'd0,  16'sh7FFF);
    send_item(FUNC_LOAD_CUR,  4'd4,  16'sh8000);
    send_item(FUNC_LOAD_CUR,  4'd8,  16'sh4000);
    send_item(FUNC_LOAD_CUR,  4'd1,  16'shFFFF);
    send_item(FUNC_LOAD_DES,  4'd2,  16'sh8000);
    send_item(FUNC_LOAD_DES,  4'd3,  16'sh7FFF);
    send_item(FUNC_LOAD_DES,  4'd6,  16'sh3039);
    send_item(FUNC_LOAD_DES,  4'd0,  16'sh4000);
    send_item(FUNC_LOAD_RATE, 4'd0,  16'sh7FFF);
    send_item(FUNC_LOAD_RATE, 4'd1,  16'sh8000);
    send_item(FUNC_LOAD_RATE, 4'd2,  16'shFFFF);
    // out-of-range indexes: drop the load
    send_item(FUNC_LOAD_CUR,  4'd9,  16'sh7FFF);
    send_item(FUNC_LOAD_DES,  4'd15, 16'sh8000);
    send_item(FUNC_LOAD_RATE, 4'd3,  16'sh7FFF);
    send_item(FUNC_LOAD_RATE, 4'd15, 16'sh8000);
    send_item(FUNC_COMPUTE,   4'd15, 16'sh8000);
    send_item(FUNC_COMPUTE,   4'd0,  16'sh0000);
    settle();
  endtask

  task automatic test_random_phases();
    int phase_mode [NUM_PHASES] = '{GAINS_RANDOM, GAINS_ALL_MAX, GAINS_ALL_MIN,
                                    GAINS_LANES, GAINS_RANDOM, GAINS_LANES};
    int target;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      gaps_on = (p != 3);
      program_gains(phase_mode[p]);
      target = item_count + PHASE_BEATS;
      while (item_count < target) run_frame();
    end
    settle();
  endtask

  initial begin
    for (int i = 0; i < MAT_DEPTH; i++) begin
      cur_m[i] = '0;
      des_m[i] = '0;
    end
    for (int i = 0; i < VEC_DEPTH; i++) rate_v[i] = '0;
    for (int i = 0; i < NUM_CFG; i++) gain_reg[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_up();
    test_directed_cases();
    test_random_phases();
    $display("covered %0d input beats, %0d of them computes, under %0d gain settings",
             item_count, compute_count, gain_settings);
    $display("checked %0d torque beats, %0d mismatches", beats_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("attitude_error_state_feedback_unit_tb: done, clean");
    end else begin
      $display("attitude_error_state_feedback_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
